// ===== rtl/core/pmofb_pkg.sv =====
// Shared types and constants for the page-mode OLED frame buffer.
package pmofb_pkg;

  localparam int PANEL_WIDTH_DEF  = 128;
  localparam int PANEL_HEIGHT_DEF = 64;

  // Page index width: at most eight pages of eight rows
  localparam int PAGE_W = 3;

  // Refresh header: page command, low column, high column
  localparam int HEADER_LEN   = 3;
  localparam int POS_PAGE_CMD = 0;
  localparam int POS_LOW_COL  = 1;
  localparam int POS_HIGH_COL = 2;

  localparam logic [7:0] PAGE_CMD_BASE = 8'hB0;
  localparam logic [7:0] HIGH_COL_CMD  = 8'h10;
  localparam logic [7:0] LOW_COL_MASK  = 8'h0F;
  localparam int         MAX_PAT_BITS  = 8;

  // Configuration port
  localparam int          CFG_AW           = 3;
  localparam int          CFG_DW           = 32;
  localparam logic [2:0]  COL_OFFSET_RESET = 3'd2;
  localparam logic [CFG_AW-3:0] REG_COLUMN_OFFSET = '0;

  typedef enum logic [1:0] {
    OP_PIXEL   = 2'd0,
    OP_BITMAP  = 2'd1,
    OP_CLEAR   = 2'd2,
    OP_REFRESH = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MODIFY,
    ST_EMIT
  } st_t;

  typedef struct packed {
    logic [7:0] data;
    logic       is_data;
    logic       frame_last;
  } result_t;

  typedef struct packed {
    logic       is_data;
    logic       frame_last;
    logic [7:0] cmd_byte;
  } ref_info_t;

endpackage

// ===== rtl/core/pmofb_ram.sv =====
// Generic simple dual-port RAM with registered read.
module pmofb_ram #(
  parameter  int WIDTH = 8,
  parameter  int DEPTH = 1024,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/pmofb_refresh.sv =====
// Refresh sequencer: page/position counters, command bytes, data address.
module pmofb_refresh #(
  parameter int PANEL_WIDTH = pmofb_pkg::PANEL_WIDTH_DEF,
  parameter int PAGE_COUNT  = 8,
  parameter int ADDR_W      = 10,
  parameter int POS_W       = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  advance,
  input  logic [2:0]            column_offset,
  output pmofb_pkg::ref_info_t  info,
  output logic [ADDR_W-1:0]     rd_addr
);

  localparam int POS_LAST = pmofb_pkg::HEADER_LEN + PANEL_WIDTH - 1;

  logic [POS_W-1:0]             pos_r, pos_nxt;
  logic [pmofb_pkg::PAGE_W-1:0] page_r, page_nxt;
  logic [15:0]                  addr_wide;
  logic                         pos_wrap;
  logic                         page_wrap;

  assign pos_wrap  = (pos_r == POS_W'(POS_LAST));
  assign page_wrap = (page_r == pmofb_pkg::PAGE_W'(PAGE_COUNT - 1));

  always_comb begin
    pos_nxt  = pos_r;
    page_nxt = page_r;
    if (advance) begin
      if (pos_wrap) begin
        pos_nxt  = '0;
        page_nxt = page_wrap ? '0 : page_r + 1'b1;
      end else begin
        pos_nxt = pos_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      page_r <= '0;
    end else begin
      pos_r  <= pos_nxt;
      page_r <= page_nxt;
    end
  end

  assign addr_wide = 16'(page_r) * 16'(PANEL_WIDTH) + 16'(pos_r)
                   - 16'(pmofb_pkg::HEADER_LEN);
  assign rd_addr   = addr_wide[ADDR_W-1:0];

  always_comb begin
    info.is_data    = (pos_r >= POS_W'(pmofb_pkg::HEADER_LEN));
    info.frame_last = pos_wrap && page_wrap;
    case (pos_r)
      POS_W'(pmofb_pkg::POS_PAGE_CMD):
        info.cmd_byte = pmofb_pkg::PAGE_CMD_BASE + 8'(page_r);
      POS_W'(pmofb_pkg::POS_LOW_COL):
        info.cmd_byte = 8'(column_offset) & pmofb_pkg::LOW_COL_MASK;
      POS_W'(pmofb_pkg::POS_HIGH_COL):
        info.cmd_byte = pmofb_pkg::HIGH_COL_CMD | (8'(column_offset) >> 4);
      default:
        info.cmd_byte = '0;
    endcase
  end

endmodule

// ===== rtl/core/pmofb_outq.sv =====
// Two-slot result queue: output register plus skid register.
module pmofb_outq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  pmofb_pkg::result_t  push_item,
  input  logic                out_stall,
  output logic                out_valid,
  output pmofb_pkg::result_t  out_item,
  output logic                full
);

  logic               head_vld_r, head_vld_nxt;
  logic               skid_vld_r, skid_vld_nxt;
  pmofb_pkg::result_t head_r, head_nxt;
  pmofb_pkg::result_t skid_r, skid_nxt;
  logic               pop;

  assign pop = head_vld_r && !out_stall;

  always_comb begin
    head_vld_nxt = head_vld_r;
    skid_vld_nxt = skid_vld_r;
    head_nxt     = head_r;
    skid_nxt     = skid_r;
    if (pop) begin
      if (skid_vld_r) begin
        head_nxt     = skid_r;
        skid_vld_nxt = push;
        skid_nxt     = push_item;
      end else begin
        head_vld_nxt = push;
        head_nxt     = push_item;
      end
    end else if (push) begin
      if (!head_vld_r) begin
        head_vld_nxt = 1'b1;
        head_nxt     = push_item;
      end else begin
        skid_vld_nxt = 1'b1;
        skid_nxt     = push_item;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_vld_r <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      head_vld_r <= head_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    head_r <= head_nxt;
    skid_r <= skid_nxt;
  end

  assign out_valid = head_vld_r;
  assign out_item  = head_r;
  assign full      = skid_vld_r;

endmodule

// ===== rtl/core/page_mode_oled_frame_buffer.sv =====
// Top level: page-organized monochrome frame store with refresh byte stream.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+-----------------------------------------
//  in_     | input     | in_valid / in_stall | operation, x_pos, y_pos, pen, pattern,
//          |           |                     | pattern_bits
//  out_    | output    | out_valid/out_stall | out_byte, is_data, frame_last
//  apb     | input     | psel/penable/pready | column_offset at word 0
//
// Pixel write: store read, then modify and write back.
// Bitmap OR: n = pattern_bits capped at 8; write of byte i overlaps read of i+1.
// Clear: one store byte per cycle, PANEL_WIDTH * pages bytes in all.
// Refresh byte: a command byte is pushed directly, a data byte after a store read.
// After reset the same clearing pass runs with in_stall high.
// in_stall is high while the sequencer is busy or both result slots are full.
module page_mode_oled_frame_buffer #(
  parameter int PANEL_WIDTH  = pmofb_pkg::PANEL_WIDTH_DEF,
  parameter int PANEL_HEIGHT = pmofb_pkg::PANEL_HEIGHT_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // input channel
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [1:0]                   in_operation,
  input  logic [7:0]                   in_x_pos,
  input  logic [7:0]                   in_y_pos,
  input  logic                         in_pen,
  input  logic [7:0]                   in_pattern,
  input  logic [3:0]                   in_pattern_bits,
  // result channel
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [7:0]                   out_byte,
  output logic                         out_is_data,
  output logic                         out_frame_last,
  // configuration
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [pmofb_pkg::CFG_AW-1:0] paddr,
  input  logic [pmofb_pkg::CFG_DW-1:0] pwdata,
  output logic [pmofb_pkg::CFG_DW-1:0] prdata,
  output logic                         pready
);

  localparam int PAGE_COUNT  = (PANEL_HEIGHT + 7) / 8;
  localparam int STORE_BYTES = PANEL_WIDTH * PAGE_COUNT;
  localparam int ADDR_W      = $clog2(STORE_BYTES);
  localparam int POS_W       = $clog2(PANEL_WIDTH + pmofb_pkg::HEADER_LEN);

  // ---------------- configuration ----------------
  logic [2:0] col_off_r;
  logic       cfg_wr;
  logic       cfg_hit;

  assign pready  = 1'b1;
  assign cfg_hit = (paddr[pmofb_pkg::CFG_AW-1:2] == pmofb_pkg::REG_COLUMN_OFFSET);
  assign cfg_wr  = psel && penable && pwrite && cfg_hit;
  assign prdata  = cfg_hit ? pmofb_pkg::CFG_DW'(col_off_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_off_r <= pmofb_pkg::COL_OFFSET_RESET;
    end else if (cfg_wr) begin
      col_off_r <= pwdata[2:0];
    end
  end

  // ---------------- sequencer state ----------------
  pmofb_pkg::st_t       state_r, state_nxt;
  logic [ADDR_W-1:0]    clr_addr_r;
  logic [7:0]           x_r;
  logic [7:0]           y_r;
  logic [7:0]           pat_r;
  logic                 lit_r;
  logic [3:0]           n_r;
  logic [2:0]           i_r;
  logic                 last_r;

  logic                 accept;
  pmofb_pkg::op_t       op;
  logic [3:0]           nbits;
  logic                 more;
  logic                 clr_done;
  logic                 outq_full;

  pmofb_pkg::ref_info_t ref_info;
  logic [ADDR_W-1:0]    ref_addr;
  logic                 ref_advance;

  logic                 ram_we;
  logic [ADDR_W-1:0]    ram_waddr;
  logic [7:0]           ram_wdata;
  logic                 ram_re;
  logic [ADDR_W-1:0]    ram_raddr;
  logic [7:0]           ram_rdata;

  logic                 push;
  pmofb_pkg::result_t   push_item;
  pmofb_pkg::result_t   out_item;

  logic [7:0]           pix_mask;
  logic                 pix_active;

  // store byte address of column x + i on the page holding row y
  function automatic logic [ADDR_W-1:0] byte_addr(input logic [7:0] x,
                                                  input logic [2:0] i,
                                                  input logic [7:0] y);
    logic [15:0] a;
    a = 16'(x) + 16'(i) + 16'(y[7:3]) * 16'(PANEL_WIDTH);
    return a[ADDR_W-1:0];
  endfunction

  function automatic logic on_panel(input logic [7:0] x,
                                    input logic [2:0] i,
                                    input logic [7:0] y);
    logic [8:0] col;
    col = 9'(x) + 9'(i);
    return (col < 9'(PANEL_WIDTH)) && (9'(y) < 9'(PANEL_HEIGHT));
  endfunction

  assign op       = pmofb_pkg::op_t'(in_operation);
  assign in_stall = (state_r != pmofb_pkg::ST_IDLE) || outq_full;
  assign accept   = in_valid && !in_stall;
  assign nbits    = (in_pattern_bits > 4'(pmofb_pkg::MAX_PAT_BITS))
                  ? 4'(pmofb_pkg::MAX_PAT_BITS) : in_pattern_bits;
  assign more     = ((4'(i_r) + 4'd1) < n_r);
  assign clr_done = (clr_addr_r == ADDR_W'(STORE_BYTES - 1));

  assign pix_mask   = 8'd1 << y_r[2:0];
  assign pix_active = pat_r[3'd7 - i_r] && on_panel(x_r, i_r, y_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      pmofb_pkg::ST_CLEAR: begin
        if (clr_done) begin
          state_nxt = pmofb_pkg::ST_IDLE;
        end
      end
      pmofb_pkg::ST_IDLE: begin
        if (accept) begin
          case (op)
            pmofb_pkg::OP_PIXEL:   state_nxt = pmofb_pkg::ST_MODIFY;
            pmofb_pkg::OP_BITMAP:  state_nxt = (nbits == 4'd0) ? pmofb_pkg::ST_IDLE
                                                                : pmofb_pkg::ST_MODIFY;
            pmofb_pkg::OP_CLEAR:   state_nxt = pmofb_pkg::ST_CLEAR;
            pmofb_pkg::OP_REFRESH: state_nxt = ref_info.is_data ? pmofb_pkg::ST_EMIT
                                                                : pmofb_pkg::ST_IDLE;
            default:               state_nxt = pmofb_pkg::ST_IDLE;
          endcase
        end
      end
      pmofb_pkg::ST_MODIFY: begin
        if (!more) begin
          state_nxt = pmofb_pkg::ST_IDLE;
        end
      end
      pmofb_pkg::ST_EMIT: state_nxt = pmofb_pkg::ST_IDLE;
      default:            state_nxt = pmofb_pkg::ST_IDLE;
    endcase
  end

  // outputs: memory ports, refresh advance, result push
  always_comb begin
    ram_we      = 1'b0;
    ram_waddr   = clr_addr_r;
    ram_wdata   = '0;
    ram_re      = 1'b0;
    ram_raddr   = ref_addr;
    ref_advance = 1'b0;
    push        = 1'b0;
    push_item   = '{data: ref_info.cmd_byte, is_data: 1'b0, frame_last: 1'b0};
    case (state_r)
      pmofb_pkg::ST_CLEAR: begin
        ram_we = 1'b1;
      end
      pmofb_pkg::ST_IDLE: begin
        if (accept) begin
          case (op)
            pmofb_pkg::OP_PIXEL, pmofb_pkg::OP_BITMAP: begin
              ram_re    = 1'b1;
              ram_raddr = byte_addr(in_x_pos, 3'd0, in_y_pos);
            end
            pmofb_pkg::OP_REFRESH: begin
              ref_advance = 1'b1;
              if (ref_info.is_data) begin
                ram_re = 1'b1;
              end else begin
                push = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      pmofb_pkg::ST_MODIFY: begin
        ram_we    = pix_active;
        ram_waddr = byte_addr(x_r, i_r, y_r);
        ram_wdata = lit_r ? (ram_rdata | pix_mask) : (ram_rdata & ~pix_mask);
        ram_re    = more;
        ram_raddr = byte_addr(x_r, i_r + 3'd1, y_r);
      end
      pmofb_pkg::ST_EMIT: begin
        push      = 1'b1;
        push_item = '{data: ram_rdata, is_data: 1'b1, frame_last: last_r};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= pmofb_pkg::ST_CLEAR;
      clr_addr_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == pmofb_pkg::ST_CLEAR) begin
        clr_addr_r <= clr_done ? '0 : clr_addr_r + 1'b1;
      end
    end
  end

  // transaction fields; a pixel write runs as a one-bit bitmap
  always_ff @(posedge clk) begin
    if (accept) begin
      x_r    <= in_x_pos;
      y_r    <= in_y_pos;
      i_r    <= '0;
      last_r <= ref_info.frame_last;
      if (op == pmofb_pkg::OP_PIXEL) begin
        pat_r <= 8'h80;
        lit_r <= in_pen;
        n_r   <= 4'd1;
      end else begin
        pat_r <= in_pattern;
        lit_r <= 1'b1;
        n_r   <= nbits;
      end
    end else if (state_r == pmofb_pkg::ST_MODIFY) begin
      i_r <= i_r + 3'd1;
    end
  end

  pmofb_ram #(
    .WIDTH (8),
    .DEPTH (STORE_BYTES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  pmofb_refresh #(
    .PANEL_WIDTH (PANEL_WIDTH),
    .PAGE_COUNT  (PAGE_COUNT),
    .ADDR_W      (ADDR_W),
    .POS_W       (POS_W)
  ) u_refresh (
    .clk           (clk),
    .rst_n         (rst_n),
    .advance       (ref_advance),
    .column_offset (col_off_r),
    .info          (ref_info),
    .rd_addr       (ref_addr)
  );

  pmofb_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_item  (out_item),
    .full      (outq_full)
  );

  assign out_byte       = out_item.data;
  assign out_is_data    = out_item.is_data;
  assign out_frame_last = out_item.frame_last;

endmodule

// ===== rtl/core/pmofb_chk.sv =====
// Port-level checker for the frame buffer, bound to the top level.
module pmofb_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_byte,
  input logic       out_is_data,
  input logic       out_frame_last
);

  // a stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_byte)
      && $stable(out_is_data) && $stable(out_frame_last))
    else $error("stalled result changed or dropped");

  // end of frame is always a data byte
  a_last_is_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_last |-> out_is_data)
    else $error("frame_last on a command byte");

  // nothing pending right after reset
  a_rst_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // store clearing pass blocks input right after reset
  a_rst_stall: assert property (@(posedge clk) !rst_n |=> in_stall)
    else $error("input not stalled during clearing pass");

endmodule

bind page_mode_oled_frame_buffer pmofb_chk u_pmofb_chk (.*);
